### rtl/core/vcp_pkg.sv
// ----------------------------------------------------------------------------
// vcp_pkg
// Shared types and constants of the video chip cpu port.
// ----------------------------------------------------------------------------
package vcp_pkg;

   localparam int VRAM_ADDR_BITS = 14;   // video memory address bits in use, 12..14
   localparam int CPU_ADDR_BITS  = 14;   // address width seen through the control port
   localparam int REG_COUNT      = 8;
   localparam int REG_IDX_BITS   = $clog2(REG_COUNT);

   // port access opcodes
   localparam logic [2:0] OP_DATA_WR   = 3'd0;
   localparam logic [2:0] OP_CTRL_WR   = 3'd1;
   localparam logic [2:0] OP_DATA_RD   = 3'd2;
   localparam logic [2:0] OP_STATUS_RD = 3'd3;
   localparam logic [2:0] OP_STATUS_SET = 3'd4;

   // access codes from the second control byte
   localparam logic [1:0] CODE_VRAM_RD = 2'd0;
   localparam logic [1:0] CODE_REG_WR  = 2'd2;

   localparam logic [7:0] REG0_MASK      = 8'h03;
   localparam logic [7:0] REG1_MASK      = 8'hFB;
   localparam logic [7:0] STATUS_KEEP    = 8'h1F;
   localparam int         IRQ_ENABLE_BIT = 5;
   localparam int         STATUS_INT_BIT = 7;

   typedef struct packed {
      logic       reg_we;
      logic [3:0] reg_num;
      logic [7:0] reg_val;
      logic       status_rd;
      logic       status_raise;
      logic [7:0] raise_bits;
   } reg_cmd_type;

   typedef struct packed {
      logic [7:0] status;
      logic       irq_next;
      logic       mode_pulse;
   } reg_sts_type;

endpackage

### rtl/core/vcp_if.sv
// ----------------------------------------------------------------------------
// vcp_req_if / vcp_rsp_if
// Valid/ready channels for port accesses and their responses.
// ----------------------------------------------------------------------------
interface vcp_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [7:0] data;

   modport source (output valid, output opcode, output data, input ready);
   modport sink   (input valid, input opcode, input data, output ready);
endinterface

interface vcp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       irq_level;
   logic       mode_update;

   modport source (output valid, output read_data, output irq_level, output mode_update,
                   input ready);
   modport sink   (input valid, input read_data, input irq_level, input mode_update,
                   output ready);
endinterface

### rtl/core/vcp_vram.sv
// ----------------------------------------------------------------------------
// vcp_vram
// Single-port synchronous video memory with a registered read port.
// ----------------------------------------------------------------------------
module vcp_vram #(
   parameter int ADDR_BITS = 14,
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic                 re,
   input  logic [ADDR_BITS-1:0] addr,
   input  logic [DATA_BITS-1:0] wdata,
   output logic [DATA_BITS-1:0] rdata
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/vcp_regfile.sv
// ----------------------------------------------------------------------------
// vcp_regfile
// Masked control registers, status flags and the interrupt line.
// ----------------------------------------------------------------------------
module vcp_regfile
   import vcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  reg_cmd_type cmd,
   output reg_sts_type sts
);

   logic [7:0] ctrl_reg_ff [REG_COUNT];
   logic [7:0] ctrl_reg_in [REG_COUNT];
   logic [7:0] status_ff;
   logic [7:0] status_in;
   logic       irq_ff;
   logic       irq_in;
   logic       pulse;

   always_comb begin
      ctrl_reg_in = ctrl_reg_ff;
      status_in   = status_ff;
      irq_in      = irq_ff;
      pulse       = 1'b0;

      // register numbers above seven are dropped
      if (cmd.reg_we && !cmd.reg_num[3]) begin
         unique case (cmd.reg_num[REG_IDX_BITS-1:0])
            REG_IDX_BITS'(0): begin
               ctrl_reg_in[0] = cmd.reg_val & REG0_MASK;
               pulse          = 1'b1;
            end
            REG_IDX_BITS'(1): begin
               ctrl_reg_in[1] = cmd.reg_val & REG1_MASK;
               pulse          = 1'b1;
               if (status_ff[STATUS_INT_BIT] && ctrl_reg_in[1][IRQ_ENABLE_BIT]) begin
                  irq_in = 1'b1;
               end
            end
            default: begin
               ctrl_reg_in[cmd.reg_num[REG_IDX_BITS-1:0]] = cmd.reg_val;
            end
         endcase
      end

      if (cmd.status_rd) begin
         if (status_ff[STATUS_INT_BIT]) begin
            irq_in = 1'b0;
         end
         status_in = status_ff & STATUS_KEEP;
      end

      if (cmd.status_raise) begin
         status_in = status_ff | cmd.raise_bits;
         if (status_in[STATUS_INT_BIT] && ctrl_reg_ff[1][IRQ_ENABLE_BIT]) begin
            irq_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            ctrl_reg_ff[i] <= '0;
         end
         status_ff <= '0;
         irq_ff    <= 1'b0;
      end else begin
         ctrl_reg_ff <= ctrl_reg_in;
         status_ff   <= status_in;
         irq_ff      <= irq_in;
      end
   end

   assign sts.status     = status_ff;
   assign sts.irq_next   = irq_in;
   assign sts.mode_pulse = pulse;

endmodule

### rtl/core/video_chip_cpu_port_unit.sv
// ----------------------------------------------------------------------------
// video_chip_cpu_port_unit
// CPU side port of a video display processor: 16K video memory behind an
// auto-incrementing address, a two-byte control latch and a read-ahead buffer.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ch carries one port access per transfer: opcode (data write, control
//    write, data read, status read, raise status) and a data byte.
//  - rsp_ch returns exactly one response per access: read_data (old read
//    buffer or status byte, zero for writes), irq_level after the access and
//    mode_update when register 0 or 1 was written.
//  - the response is registered and shows up in the cycle after its request.
//  - accesses that read video memory (data read, control write with access
//    code 0) then enter the fill state, as the single memory port registers
//    the prefetch byte; req_ch is not ready there. Other accesses stay idle.
//  - while a response waits on rsp_ch the next request is still taken if the
//    receiver takes the response in the same cycle; otherwise req_ch stalls.
//  - synchronous reset clears address, latch, buffer, registers, status and
//    the interrupt line; video memory contents stay undefined until written.
// ----------------------------------------------------------------------------
module video_chip_cpu_port_unit
   import vcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   vcp_req_if.sink    req_ch,
   vcp_rsp_if.source  rsp_ch
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_FILL = 1'b1;

   logic                      state_ff, state_in;
   logic [VRAM_ADDR_BITS-1:0] addr_ff, addr_in;
   logic [7:0]                latch_ff, latch_in;
   logic [1:0]                code_ff, code_in;
   logic                      pend_ff, pend_in;
   logic [7:0]                buf_ff, buf_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_data_ff, rsp_data_in;
   logic                      rsp_irq_ff;
   logic                      rsp_mode_ff;

   logic                      accept;
   logic [CPU_ADDR_BITS-1:0]  addr_full;
   logic [VRAM_ADDR_BITS-1:0] addr_new;
   logic                      mem_we, mem_re;
   logic [VRAM_ADDR_BITS-1:0] mem_addr;
   logic [7:0]                mem_rdata;
   reg_cmd_type               cmd;
   reg_sts_type               sts;

   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;
   assign addr_full    = CPU_ADDR_BITS'(addr_ff);
   assign addr_new     = VRAM_ADDR_BITS'({req_ch.data[5:0], latch_ff});

   always_comb begin
      state_in    = ST_IDLE;
      addr_in     = addr_ff;
      latch_in    = latch_ff;
      code_in     = code_ff;
      pend_in     = pend_ff;
      buf_in      = buf_ff;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_addr    = addr_ff;
      rsp_data_in = '0;
      cmd         = '0;
      cmd.reg_val    = latch_ff;
      cmd.reg_num    = req_ch.data[3:0];
      cmd.raise_bits = req_ch.data;

      // prefetch byte lands in the cycle after the read was issued
      if (state_ff == ST_FILL) begin
         buf_in = mem_rdata;
      end

      if (accept) begin
         unique case (req_ch.opcode)
            OP_DATA_WR: begin
               pend_in = 1'b0;
               buf_in  = req_ch.data;
               mem_we  = 1'b1;
               addr_in = addr_ff + VRAM_ADDR_BITS'(1);
            end
            OP_CTRL_WR: begin
               if (!pend_ff) begin
                  addr_in  = VRAM_ADDR_BITS'({addr_full[CPU_ADDR_BITS-1:8], req_ch.data});
                  latch_in = req_ch.data;
                  pend_in  = 1'b1;
               end else begin
                  addr_in = addr_new;
                  code_in = req_ch.data[7:6];
                  pend_in = 1'b0;
                  if (req_ch.data[7:6] == CODE_VRAM_RD) begin
                     mem_addr = addr_new;
                     mem_re   = 1'b1;
                     state_in = ST_FILL;
                     addr_in  = addr_new + VRAM_ADDR_BITS'(1);
                  end else if (req_ch.data[7:6] == CODE_REG_WR) begin
                     cmd.reg_we = 1'b1;
                  end
               end
            end
            OP_DATA_RD: begin
               pend_in     = 1'b0;
               rsp_data_in = buf_ff;
               mem_re      = 1'b1;
               state_in    = ST_FILL;
               addr_in     = addr_ff + VRAM_ADDR_BITS'(1);
            end
            OP_STATUS_RD: begin
               pend_in       = 1'b0;
               cmd.status_rd = 1'b1;
               rsp_data_in   = sts.status;
            end
            OP_STATUS_SET: begin
               cmd.status_raise = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   vcp_vram #(
      .ADDR_BITS (VRAM_ADDR_BITS),
      .DATA_BITS (8)
   ) u_vram (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (req_ch.data),
      .rdata (mem_rdata)
   );

   vcp_regfile u_regfile (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         addr_ff      <= '0;
         latch_ff     <= '0;
         code_ff      <= '0;
         pend_ff      <= 1'b0;
         buf_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         latch_ff     <= latch_in;
         code_ff      <= code_in;
         pend_ff      <= pend_in;
         buf_ff       <= buf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_irq_ff  <= sts.irq_next;
         rsp_mode_ff <= sts.mode_pulse;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_data   = rsp_data_ff;
   assign rsp_ch.irq_level   = rsp_irq_ff;
   assign rsp_ch.mode_update = rsp_mode_ff;

endmodule
